// ===== sv/bbt_pkg.sv =====
// Shared types and constants for the byte budget throttle.
package bbt_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned XFER_W   = 8;
  localparam int unsigned BYTES_W  = 26;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned BUF_W    = 21;
  localparam int unsigned MS_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = BUF_W;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RETURN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BUFFER   = 2'd2;

  localparam logic [BUF_W-1:0]   BUF_RESET    = 21'd65536;
  localparam logic [MS_W-1:0]    CYCLE_FULL   = 7'd100;
  localparam logic [9:0]         MS_PER_S     = 10'd1000;
  localparam logic [BYTES_W-1:0] UNLIMITED_GRANT = '1;

  // Shared divider: 31-bit dividend (1000*buffer or budget), 26-bit divisor
  localparam int unsigned DIVIDEND_W = 31;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
  localparam int unsigned PROD_W     = 33;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [XFER_W-1:0]  active_transfers;
    logic [BYTES_W-1:0] returned_bytes;
  } item_t;

  typedef struct packed {
    logic [BYTES_W-1:0] granted_bytes;
    logic               unlimited;
    logic [MS_W-1:0]    cycle_time_ms;
  } result_t;

  typedef struct packed {
    logic accept;
    logic mul_load;
    logic div_load;
    logic div_step;
    logic finish;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic tick_active;
  } status_t;

endpackage

// ===== sv/bbt_ctrl.sv =====
// Sequencer for the throttle: short ops from idle and the sequenced tick setup.
module bbt_ctrl
  import bbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  step_cnt, step_cnt_next;
  logic               long_tick;

  assign long_tick = status.is_tick && status.tick_active;

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        cmd.accept   = start;
        cmd.res_load = start && !long_tick;
        if (start && long_tick) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load  = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish   = 1'b1;
        cmd.res_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      done     <= cmd.res_load;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/bbt_dp.sv =====
// Datapath: config registers, budget state, tick multiplier and restoring divider.
module bbt_dp
  import bbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  item_t                 item,
  input  cmd_t                  cmd,
  output status_t               status,
  output result_t               result
);

  logic               throttle_on;
  logic [LIMIT_W-1:0] limit_kib;
  logic [BUF_W-1:0]   in_buf;

  logic [BYTES_W-1:0] budget, budget_next;
  logic               active, active_next;
  logic [BUF_W-1:0]   slice, slice_next;
  logic [BYTES_W-1:0] spent, spent_next;
  logic [MS_W-1:0]    cycle, cycle_next;

  logic [XFER_W-1:0]     xfers;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] prod_ms;
  logic                  per_xfer;
  logic [DIVIDEND_W-1:0] dq;
  logic [BYTES_W-1:0]    drem;
  logic [BYTES_W-1:0]    divisor;

  logic [BYTES_W-1:0] granted;
  logic [BYTES_W-1:0] left;
  logic [BUF_W:0]     slice2;
  logic [XFER_W+3:0]  xfers10;
  logic [XFER_W+2:0]  xfers7;
  logic [BYTES_W:0]   rem_sh;
  logic               rem_ge;
  logic [BYTES_W-1:0] quot;

  assign status.is_tick     = (item.func == FUNC_TICK);
  assign status.tick_active = throttle_on && (limit_kib != '0) && (item.active_transfers != '0);

  assign slice2  = {slice, 1'b0};
  assign xfers10 = {1'b0, xfers, 3'b000} + {3'b000, xfers, 1'b0};
  assign xfers7  = {xfers, 3'b000} - {3'b000, xfers};
  assign rem_sh  = {drem, dq[DIVIDEND_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});
  assign quot    = dq[BYTES_W-1:0];

  always_comb begin
    budget_next = budget;
    active_next = active;
    slice_next  = slice;
    spent_next  = spent;
    cycle_next  = cycle;
    granted     = '0;
    left        = (budget > spent) ? (budget - spent) : '0;
    if (cmd.accept) begin
      case (item.func)
        FUNC_TICK: begin
          budget_next = {limit_kib, 10'd0};
          active_next = status.tick_active;
          spent_next  = '0;
        end
        FUNC_REQUEST: begin
          if (!active) begin
            granted = UNLIMITED_GRANT;
          end else if (left != '0) begin
            granted    = (left > {{(BYTES_W-BUF_W-1){1'b0}}, slice2})
                         ? BYTES_W'(slice) : left;
            spent_next = spent + granted;
          end
        end
        FUNC_RETURN: begin
          if ((item.returned_bytes != '0) &&
              (item.returned_bytes < BYTES_W'(slice2))) begin
            spent_next = (spent > item.returned_bytes) ? (spent - item.returned_bytes) : '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.finish) begin
      if (per_xfer) begin
        slice_next = (quot > BYTES_W'(in_buf)) ? in_buf : quot[BUF_W-1:0];
        cycle_next = CYCLE_FULL;
      end else begin
        slice_next = in_buf;
        cycle_next = dq[MS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_on <= 1'b0;
      limit_kib   <= '0;
      in_buf      <= BUF_RESET;
      budget      <= '0;
      active      <= 1'b0;
      slice       <= '0;
      spent       <= '0;
      cycle       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_THROTTLE_ON: throttle_on <= cfg_data[0];
          CFG_LIMIT:       limit_kib   <= cfg_data[LIMIT_W-1:0];
          CFG_IN_BUFFER:   in_buf      <= cfg_data[BUF_W-1:0];
          default: begin
          end
        endcase
      end
      budget <= budget_next;
      active <= active_next;
      slice  <= slice_next;
      spent  <= spent_next;
      cycle  <= cycle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      xfers <= item.active_transfers;
    end
    if (cmd.mul_load) begin
      prod    <= PROD_W'(in_buf) * PROD_W'(xfers10);
      prod_ms <= DIVIDEND_W'(in_buf) * DIVIDEND_W'(MS_PER_S);
    end
    if (cmd.div_load) begin
      per_xfer <= ({{(PROD_W-BYTES_W){1'b0}}, budget} <= prod);
      drem     <= '0;
      if ({{(PROD_W-BYTES_W){1'b0}}, budget} <= prod) begin
        dq      <= DIVIDEND_W'(budget);
        divisor <= BYTES_W'(xfers7);
      end else begin
        dq      <= prod_ms;
        divisor <= budget;
      end
    end
    if (cmd.div_step) begin
      drem <= rem_ge ? BYTES_W'(rem_sh - {1'b0, divisor}) : rem_sh[BYTES_W-1:0];
      dq   <= {dq[DIVIDEND_W-2:0], rem_ge};
    end
    if (cmd.res_load) begin
      result.granted_bytes <= granted;
      result.unlimited     <= !active_next;
      result.cycle_time_ms <= cycle_next;
    end
  end

endmodule

// ===== sv/byte_budget_throttle_core.sv =====
// Byte budget throttle: tick setup, slice grants and byte returns per interval.
// Request, return, unknown items and ticks that leave throttling off: result in the
//   cycle after acceptance, one item per cycle.
// Tick that enables throttling: result and next accept follow the multiply and load
//   steps, the 31-step restoring divider and the finish step; busy is high meanwhile.
// Synchronous reset clears budget state and config (buffer size back to 64 KiB);
//   grants are unlimited until the first tick. done is never stalled.
module byte_budget_throttle_core
  import bbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  bbt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bbt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

  a_short_op_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func != FUNC_TICK) |=> done)
    else $error("short item produced no result");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without an item");

  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result while tick setup in progress");

  a_limited_grant: assert property (@(posedge clk) disable iff (rst)
    (done && result.unlimited) |-> (result.granted_bytes == '0 ||
                                    result.granted_bytes == UNLIMITED_GRANT))
    else $error("finite grant while unlimited");

endmodule
